// ----- src/gic_pkg.sv -----
// shared types, constants and register codes for the gamepad input conditioner
package gic_pkg;

    localparam logic [14:0] AXIS_FULL     = 15'd32767;
    localparam logic [14:0] LOOK_MIN_AXIS = 15'd12000;

    localparam int DUCK_QUEUE_MAX_DEF    = 255;
    localparam int WEAPON_STEP_LIMIT_DEF = 1024;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DZ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOK_DZ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_DZ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USE_THR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOOK_DIV  = 3'd7;

    localparam logic [14:0] RST_MOVE_DZ  = 15'd8000;
    localparam logic [14:0] RST_LOOK_DZ  = 15'd7000;
    localparam logic [14:0] RST_TRIG_DZ  = 15'd6000;
    localparam logic [14:0] RST_KEY_THR  = 15'd7000;
    localparam logic [14:0] RST_RUN_THR  = 15'd22000;
    localparam logic [14:0] RST_FIRE_THR = 15'd12000;
    localparam logic [14:0] RST_USE_THR  = 15'd12000;
    localparam logic [14:0] RST_LOOK_DIV = 15'd1500;

    // division operations in issue order
    typedef enum logic [2:0] {
        OP_LX   = 3'd0,
        OP_LY   = 3'd1,
        OP_RX   = 3'd2,
        OP_LT   = 3'd3,
        OP_RT   = 3'd4,
        OP_LOOK = 3'd5
    } op_t;

    typedef struct packed {
        logic latch;
        logic start;
        logic store;
        logic finish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

// ----- src/gamepad_input_conditioner.sv -----
// top level of the gamepad input conditioner
// One request per frame: five raw axes are clamped, dead-zoned and rescaled,
// then turned into stick motion, key bits and a look step, while button rising
// edges feed the duck queue, weapon step total and map flags, which are handed
// out when the request asks for them. From acceptance until its result is
// offered, each request runs six divisions (five axis rescales and the look
// divisor) one after another on a single shared divider that retires two
// quotient bits per cycle, each division after an operand setup state, and
// then loads the result register. The quadratic look term is divided by
// full scale with a shift and add, off the divider.
// One request is in work at a time; a finished result waits in the output
// register so the next request can be accepted while it is held, and a result
// still stalled when the next one is ready delays that load.
// Configuration writes are always ready and must only be issued while idle.
module gamepad_input_conditioner #(
    parameter int DUCK_QUEUE_MAX    = gic_pkg::DUCK_QUEUE_MAX_DEF,
    parameter int WEAPON_STEP_LIMIT = gic_pkg::WEAPON_STEP_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gic_pkg::CFG_W-1:0]       cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [15:0]              left_x,
    input  logic signed [15:0]              left_y,
    input  logic signed [15:0]              right_x,
    input  logic [14:0]                     left_trigger,
    input  logic [14:0]                     right_trigger,
    input  logic [10:0]                     button_mask,
    input  logic                            pad_present,
    input  logic                            take_duck,
    input  logic                            take_weapon_steps,
    input  logic                            take_map_flags,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [7:0]               move_x,
    output logic signed [7:0]               move_y,
    output logic                            fire_active,
    output logic [8:0]                      key_mask,
    output logic signed [5:0]               look_delta,
    output logic                            duck_granted,
    output logic signed [11:0]              weapon_steps,
    output logic                            map_toggle,
    output logic                            map_page_up,
    output logic                            map_page_down
);

    gic_pkg::cmd_t    cmd;
    gic_pkg::status_t status;

    // config registers accept a write every cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, step through the divisions, load the result register
    gic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic, edge state and output payload
    gic_dp #(
        .DUCK_QUEUE_MAX    (DUCK_QUEUE_MAX),
        .WEAPON_STEP_LIMIT (WEAPON_STEP_LIMIT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .left_x            (left_x),
        .left_y            (left_y),
        .right_x           (right_x),
        .left_trigger      (left_trigger),
        .right_trigger     (right_trigger),
        .button_mask       (button_mask),
        .pad_present       (pad_present),
        .take_duck         (take_duck),
        .take_weapon_steps (take_weapon_steps),
        .take_map_flags    (take_map_flags),
        .move_x            (move_x),
        .move_y            (move_y),
        .fire_active       (fire_active),
        .key_mask          (key_mask),
        .look_delta        (look_delta),
        .duck_granted      (duck_granted),
        .weapon_steps      (weapon_steps),
        .map_toggle        (map_toggle),
        .map_page_up       (map_page_up),
        .map_page_down     (map_page_down)
    );

endmodule

// ----- src/gic_div.sv -----
// iterative restoring divider, two quotient bits per cycle
module gic_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [29:0] dividend,
    input  logic [14:0] divisor,
    output logic        done,
    output logic [14:0] quotient
);

    logic [14:0] rem_reg, rem_next;
    logic [29:0] dvd_reg, dvd_next;
    logic [14:0] dvs_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [15:0] t1, t2;
    logic [14:0] r1;
    logic        q1, q2;

    always_comb
    begin
        t1 = {rem_reg, dvd_reg[29]};
        q1 = (t1 >= {1'b0, dvs_reg});
        r1 = q1 ? 15'(t1 - {1'b0, dvs_reg}) : t1[14:0];
        t2 = {r1, dvd_reg[28]};
        q2 = (t2 >= {1'b0, dvs_reg});
        rem_next = q2 ? 15'(t2 - {1'b0, dvs_reg}) : t2[14:0];
        dvd_next = {dvd_reg[27:0], q1, q2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd14)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[14:0];

endmodule

// ----- src/gic_ctrl.sv -----
// sequencing state machine for the gamepad input conditioner
module gic_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  gic_pkg::status_t status,
    output gic_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PREP   = 4'b0010,
        S_RUN    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    gic_pkg::op_t   op_reg, op_next;
    logic           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    op_next    = gic_pkg::OP_LX;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.start  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.store = 1'b1;
                    if (op_reg == gic_pkg::OP_LOOK)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        op_next    = gic_pkg::op_t'(op_reg + 3'd1);
                        state_next = S_PREP;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= gic_pkg::OP_LX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- src/gic_dp.sv -----
// datapath: config registers, axis conditioning, look curve, edge counters, result register
module gic_dp #(
    parameter int DUCK_QUEUE_MAX    = gic_pkg::DUCK_QUEUE_MAX_DEF,
    parameter int WEAPON_STEP_LIMIT = gic_pkg::WEAPON_STEP_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gic_pkg::cmd_t                   cmd,
    output gic_pkg::status_t                status,
    input  logic                            cfg_we,
    input  logic [gic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gic_pkg::CFG_W-1:0]       cfg_data,
    input  logic signed [15:0]              left_x,
    input  logic signed [15:0]              left_y,
    input  logic signed [15:0]              right_x,
    input  logic [14:0]                     left_trigger,
    input  logic [14:0]                     right_trigger,
    input  logic [10:0]                     button_mask,
    input  logic                            pad_present,
    input  logic                            take_duck,
    input  logic                            take_weapon_steps,
    input  logic                            take_map_flags,
    output logic signed [7:0]               move_x,
    output logic signed [7:0]               move_y,
    output logic                            fire_active,
    output logic [8:0]                      key_mask,
    output logic signed [5:0]               look_delta,
    output logic                            duck_granted,
    output logic signed [11:0]              weapon_steps,
    output logic                            map_toggle,
    output logic                            map_page_up,
    output logic                            map_page_down
);

    localparam logic [7:0]         DUCK_MAX = 8'(DUCK_QUEUE_MAX);
    localparam logic signed [11:0] W_MAX    = 12'(WEAPON_STEP_LIMIT);
    localparam logic signed [11:0] W_MIN    = 12'(-WEAPON_STEP_LIMIT);

    // configuration
    logic [14:0] move_dz_reg, look_dz_reg, trig_dz_reg, key_thr_reg;
    logic [14:0] run_thr_reg, fire_thr_reg, use_thr_reg, look_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_dz_reg  <= gic_pkg::RST_MOVE_DZ;
            look_dz_reg  <= gic_pkg::RST_LOOK_DZ;
            trig_dz_reg  <= gic_pkg::RST_TRIG_DZ;
            key_thr_reg  <= gic_pkg::RST_KEY_THR;
            run_thr_reg  <= gic_pkg::RST_RUN_THR;
            fire_thr_reg <= gic_pkg::RST_FIRE_THR;
            use_thr_reg  <= gic_pkg::RST_USE_THR;
            look_div_reg <= gic_pkg::RST_LOOK_DIV;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gic_pkg::REG_MOVE_DZ:  move_dz_reg  <= cfg_data;
                gic_pkg::REG_LOOK_DZ:  look_dz_reg  <= cfg_data;
                gic_pkg::REG_TRIG_DZ:  trig_dz_reg  <= cfg_data;
                gic_pkg::REG_KEY_THR:  key_thr_reg  <= cfg_data;
                gic_pkg::REG_RUN_THR:  run_thr_reg  <= cfg_data;
                gic_pkg::REG_FIRE_THR: fire_thr_reg <= cfg_data;
                gic_pkg::REG_USE_THR:  use_thr_reg  <= cfg_data;
                gic_pkg::REG_LOOK_DIV: look_div_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // latched request
    logic signed [15:0] lx_reg, ly_reg, rx_reg;
    logic [14:0]        lt_reg, rt_reg;
    logic [10:0]        btn_reg;
    logic               present_reg, tduck_reg, tweap_reg, tmap_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            lx_reg      <= left_x;
            ly_reg      <= left_y;
            rx_reg      <= right_x;
            lt_reg      <= left_trigger;
            rt_reg      <= right_trigger;
            btn_reg     <= button_mask;
            present_reg <= pad_present;
            tduck_reg   <= take_duck;
            tweap_reg   <= take_weapon_steps;
            tmap_reg    <= take_map_flags;
        end
    end

    // operand selection for the shared divider
    logic signed [16:0] raw;
    logic [16:0]        mag17;
    logic [14:0]        mag, dz, diff, divisor, quotient;
    logic [29:0]        dividend;
    logic               kill, div_done;
    logic [14:0]        lx_mag_reg, ly_mag_reg, rx_mag_reg, lt_mag_reg, rt_mag_reg;
    logic               lx_neg_reg, ly_neg_reg, rx_neg_reg;
    logic [29:0]        sq_reg;
    logic [30:0]        sq_sum;
    logic [14:0]        sq_q_reg, look_q_reg;
    logic [15:0]        shaped_sum;

    always_comb
    begin
        unique case (cmd.op)
            gic_pkg::OP_LX: raw = {lx_reg[15], lx_reg};
            gic_pkg::OP_LY: raw = {ly_reg[15], ly_reg};
            gic_pkg::OP_RX: raw = {rx_reg[15], rx_reg};
            gic_pkg::OP_LT: raw = {2'b00, lt_reg};
            gic_pkg::OP_RT: raw = {2'b00, rt_reg};
            default:        raw = '0;
        endcase
        unique case (cmd.op)
            gic_pkg::OP_LX, gic_pkg::OP_LY: dz = move_dz_reg;
            gic_pkg::OP_RX:                 dz = look_dz_reg;
            default:                        dz = trig_dz_reg;
        endcase
        mag17      = raw[16] ? 17'(-raw) : 17'(raw);
        mag        = (mag17 > 17'd32767) ? gic_pkg::AXIS_FULL : mag17[14:0];
        kill       = (mag <= dz);
        diff       = mag - dz;
        // x / 32767 as (x + x/32768 + 1) / 32768, exact for x below 2^30 - 1
        sq_sum     = {1'b0, sq_reg} + {16'd0, sq_reg[29:15]} + 31'd1;
        shaped_sum = {1'b0, rx_mag_reg} + {1'b0, sq_q_reg};
        unique case (cmd.op)
            gic_pkg::OP_LOOK:
            begin
                dividend = {15'd0, shaped_sum[15:1]};
                divisor  = (look_div_reg == 15'd0) ? 15'd1 : look_div_reg;
            end
            default:
            begin
                // (mag - dz) * 32767
                dividend = {diff, 15'd0} - {15'd0, diff};
                divisor  = gic_pkg::AXIS_FULL - dz;
            end
        endcase
    end

    gic_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_done = div_done;

    always_ff @(posedge clk)
    begin
        sq_reg   <= 30'(rx_mag_reg) * 30'(rx_mag_reg);
        sq_q_reg <= sq_sum[29:15];
        if (cmd.store)
        begin
            unique case (cmd.op)
                gic_pkg::OP_LX:
                begin
                    lx_mag_reg <= kill ? 15'd0 : quotient;
                    lx_neg_reg <= raw[16];
                end
                gic_pkg::OP_LY:
                begin
                    ly_mag_reg <= kill ? 15'd0 : quotient;
                    ly_neg_reg <= raw[16];
                end
                gic_pkg::OP_RX:
                begin
                    rx_mag_reg <= kill ? 15'd0 : quotient;
                    rx_neg_reg <= raw[16];
                end
                gic_pkg::OP_LT:   lt_mag_reg <= kill ? 15'd0 : quotient;
                gic_pkg::OP_RT:   rt_mag_reg <= kill ? 15'd0 : quotient;
                gic_pkg::OP_LOOK: look_q_reg <= quotient;
                default: ;
            endcase
        end
    end

    // frame results
    logic [14:0]        mag_max, dlt;
    logic               fire_c;
    logic [8:0]         keys_c;
    logic signed [7:0]  mx_c, my_c;
    logic signed [5:0]  look_c;
    logic [5:0]         now_c, rise_c;
    logic [5:0]         prev_reg, prev_next;
    logic [7:0]         duck_reg, duck_mid, duck_next;
    logic signed [11:0] weap_reg, weap_inc, weap_mid, weap_next;
    logic [2:0]         map_reg, map_mid, map_next;

    always_comb
    begin
        mag_max = (ly_mag_reg > lx_mag_reg) ? ly_mag_reg : lx_mag_reg;
        fire_c  = (rt_mag_reg >= fire_thr_reg);
        mx_c    = lx_neg_reg ? 8'(-{1'b0, lx_mag_reg[14:8]}) : {1'b0, lx_mag_reg[14:8]};
        my_c    = ly_neg_reg ? 8'(-{1'b0, ly_mag_reg[14:8]}) : {1'b0, ly_mag_reg[14:8]};
        keys_c[0] = ly_neg_reg && (ly_mag_reg > key_thr_reg);
        keys_c[1] = !ly_neg_reg && (ly_mag_reg > key_thr_reg);
        keys_c[2] = lx_neg_reg && (lx_mag_reg > key_thr_reg);
        keys_c[3] = !lx_neg_reg && (lx_mag_reg > key_thr_reg);
        keys_c[4] = btn_reg[5] || (mag_max >= run_thr_reg);
        keys_c[5] = fire_c;
        keys_c[6] = (lt_mag_reg >= use_thr_reg) || btn_reg[0];
        keys_c[7] = btn_reg[6] || btn_reg[2];
        keys_c[8] = btn_reg[4];

        // minimum step once the stick is well deflected
        dlt = (look_q_reg == 15'd0 && rx_mag_reg >= gic_pkg::LOOK_MIN_AXIS) ? 15'd1
                                                                             : look_q_reg;
        if (rx_mag_reg == 15'd0)
            look_c = '0;
        else if (rx_neg_reg)
            look_c = (dlt > 15'd32) ? 6'b100000 : 6'(-dlt[5:0]);
        else
            look_c = (dlt > 15'd31) ? 6'd31 : dlt[5:0];

        now_c  = {btn_reg[10], btn_reg[9], btn_reg[8], btn_reg[7], btn_reg[3], btn_reg[1]};
        rise_c = now_c & ~prev_reg;

        if (present_reg)
        begin
            prev_next = now_c;
            duck_mid  = (rise_c[0] && duck_reg < DUCK_MAX) ? duck_reg + 8'd1 : duck_reg;
            weap_inc  = (rise_c[2] && weap_reg < W_MAX) ? weap_reg + 12'sd1 : weap_reg;
            weap_mid  = (rise_c[3] && weap_inc > W_MIN) ? weap_inc - 12'sd1 : weap_inc;
            map_mid   = map_reg | {rise_c[5], rise_c[4], rise_c[1]};
        end
        else
        begin
            prev_next = '0;
            duck_mid  = '0;
            weap_inc  = '0;
            weap_mid  = '0;
            map_mid   = map_reg;
        end

        duck_next = (tduck_reg && duck_mid != 8'd0) ? duck_mid - 8'd1 : duck_mid;
        weap_next = tweap_reg ? 12'sd0 : weap_mid;
        map_next  = tmap_reg ? 3'd0 : map_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            duck_reg <= '0;
            weap_reg <= '0;
            map_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            prev_reg <= prev_next;
            duck_reg <= duck_next;
            weap_reg <= weap_next;
            map_reg  <= map_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            move_x        <= present_reg ? mx_c : 8'sd0;
            move_y        <= present_reg ? my_c : 8'sd0;
            fire_active   <= present_reg && fire_c;
            key_mask      <= present_reg ? keys_c : 9'd0;
            look_delta    <= present_reg ? look_c : 6'sd0;
            duck_granted  <= tduck_reg && (duck_mid != 8'd0);
            weapon_steps  <= tweap_reg ? weap_mid : 12'sd0;
            map_toggle    <= tmap_reg && map_mid[0];
            map_page_up   <= tmap_reg && map_mid[1];
            map_page_down <= tmap_reg && map_mid[2];
        end
    end

endmodule

// ----- src/gic_checker.sv -----
// port-level checks for the gamepad input conditioner
module gic_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              fire_active,
    input logic [8:0]        key_mask,
    input logic signed [5:0] look_delta
);

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one still in work");

    // a result only appears after the sequencer was busy
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

    // fire key mirrors the fire flag
    a_fire_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_mask[5] == fire_active))
        else $error("fire key and fire flag disagree");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(look_delta) && $stable(key_mask))
        else $error("stalled result dropped or changed");

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fire_active (fire_active),
    .key_mask    (key_mask),
    .look_delta  (look_delta)
);
